// ===== src/streaming_topk_selector_defines.svh =====
// ----------------------------------------------------------------------------
// Streaming top-k selector: assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STREAMING_TOPK_SELECTOR_DEFINES_SVH
`define STREAMING_TOPK_SELECTOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define TKS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tks_pkg.sv =====
// ----------------------------------------------------------------------------
// Streaming top-k selector: package
// Shared constants, register indexes, cell control types and FSM states.
// ----------------------------------------------------------------------------
package tks_pkg;

    // Default sizes
    localparam int DEF_MAX_KEEP      = 16;
    localparam int DEF_VALUE_BITS    = 16;
    localparam int DEF_POSITION_BITS = 16;

    // Configuration port
    localparam int KEEP_COUNT_BITS = 5;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 5;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_KEEP_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WANT_LARGEST = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SORTED_MODE  = 2'd2;

    localparam logic [KEEP_COUNT_BITS-1:0] RST_KEEP_COUNT   = 5'd1;
    localparam logic                       RST_WANT_LARGEST = 1'b1;
    localparam logic                       RST_SORTED_MODE  = 1'b1;

    // What a cell does with its entry: hold, insert or shift
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } cell_op_t;

    // How a new transaction is ranked against a held entry
    typedef enum logic [1:0] {
        CMP_LARGEST,
        CMP_SMALLEST,
        CMP_POSITION,
        CMP_APPEND
    } cmp_mode_t;

    typedef struct packed {
        cell_op_t  op;
        cmp_mode_t cmp;
    } cell_ctrl_t;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

endpackage

// ===== src/tks_in_if.sv =====
// ----------------------------------------------------------------------------
// Streaming top-k selector: input channel
// Valid/ready channel carrying one row element and its end-of-row flag.
// ----------------------------------------------------------------------------
interface tks_in_if
    import tks_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
)
();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] sample_value;
    logic                         row_end;

    modport source (output valid, output sample_value, output row_end, input ready);
    modport sink   (input valid, input sample_value, input row_end, output ready);
endinterface

// ===== src/tks_out_if.sv =====
// ----------------------------------------------------------------------------
// Streaming top-k selector: result channel
// Valid/ready channel carrying one selected element per transaction.
// ----------------------------------------------------------------------------
interface tks_out_if
    import tks_pkg::*;
#(
    parameter int VALUE_BITS    = DEF_VALUE_BITS,
    parameter int POSITION_BITS = DEF_POSITION_BITS
)
();
    logic                            valid;
    logic                            ready;
    logic signed [VALUE_BITS-1:0]    kept_value;
    logic        [POSITION_BITS-1:0] kept_position;
    logic                            final_result;
    logic                            row_too_long;

    modport source (output valid, output kept_value, output kept_position,
                    output final_result, output row_too_long, input ready);
    modport sink   (input valid, input kept_value, input kept_position,
                    input final_result, input row_too_long, output ready);
endinterface

// ===== src/streaming_topk_selector.sv =====
// ----------------------------------------------------------------------------
// Streaming top-k selector
// Keeps the best keep_count elements of each row and emits them at row end.
//
// Usage:
//   sample_in carries one row element per transaction; row_end marks the last.
//   result_out carries the kept elements: best first when sorted_mode is 1,
//   ascending position when 0. final_result marks the row's last result;
//   row_too_long marks every result of a row longer than 2^POSITION_BITS.
//   cfg_we/cfg_index/cfg_data write keep_count, want_largest, sorted_mode;
//   write only between rows.
// Timing:
//   Row elements are taken one per cycle; each is ranked and inserted by the
//   kept-list cell chain in that cycle. After row_end, input stalls; once the
//   previous row's results have all left the output chain, the n kept entries
//   move into it, one per cycle, and then a finishing step runs. Results then
//   leave one per cycle, while the receiver is ready, through an output
//   register as the next row streams in.
// Reset clears the lists, counters and output register; registers return to
//   keep_count 1, want_largest 1, sorted_mode 1. A stalled receiver holds the
//   output register; the next row keeps streaming until its own row_end.
// ----------------------------------------------------------------------------
`include "streaming_topk_selector_defines.svh"

module streaming_topk_selector
    import tks_pkg::*;
#(
    parameter int MAX_KEEP      = DEF_MAX_KEEP,
    parameter int VALUE_BITS    = DEF_VALUE_BITS,
    parameter int POSITION_BITS = DEF_POSITION_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    tks_in_if.sink                    sample_in,
    tks_out_if.source                 result_out
);

    localparam int KW = $clog2(MAX_KEEP + 1);

    // Configuration registers
    logic [KEEP_COUNT_BITS-1:0] keep_count_reg;
    logic                       want_largest_reg;
    logic                       sorted_mode_reg;
    logic [KW-1:0]              keep_eff;
    logic [MAX_KEEP-1:0]        main_range;

    // Row tracking
    logic [POSITION_BITS:0]     counter_reg;
    logic [POSITION_BITS:0]     counter_next;
    logic                       overflow_reg;
    logic                       overflow_next;
    logic                       row_ovf_reg;
    logic                       row_ovf_next;
    logic [POSITION_BITS-1:0]   sample_position;

    // Control
    state_t                     state_reg;
    state_t                     state_next;
    logic                       sample_ready;
    logic                       in_acc;
    logic                       drain_active;
    logic                       drain_move;
    logic                       drain_done;
    logic                       emit_shift;
    logic                       emit_last;
    logic                       loaded_reg;
    logic                       loaded_next;
    cell_ctrl_t                 main_ctrl;
    cell_ctrl_t                 sort_ctrl;

    // Chains
    logic                            main_taken;
    logic        [MAX_KEEP-1:0]      main_valid;
    logic signed [VALUE_BITS-1:0]    main_head_value;
    logic        [POSITION_BITS-1:0] main_head_position;
    logic                            sort_taken;
    logic        [MAX_KEEP-1:0]      sort_valid;
    logic signed [VALUE_BITS-1:0]    sort_head_value;
    logic        [POSITION_BITS-1:0] sort_head_position;

    // Output register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic signed [VALUE_BITS-1:0]    out_value_reg;
    logic        [POSITION_BITS-1:0] out_position_reg;
    logic                            out_final_reg;
    logic                            out_long_reg;
    logic                            out_long_src_reg;
    logic                            out_long_src_next;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg   <= RST_KEEP_COUNT;
            want_largest_reg <= RST_WANT_LARGEST;
            sorted_mode_reg  <= RST_SORTED_MODE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEEP_COUNT:   keep_count_reg   <= cfg_data[KEEP_COUNT_BITS-1:0];
                CFG_WANT_LARGEST: want_largest_reg <= cfg_data[0];
                CFG_SORTED_MODE:  sorted_mode_reg  <= cfg_data[0];
                default:          keep_count_reg   <= keep_count_reg;
            endcase
        end
    end

    // Clamp the keep count; zero or too large means all cells
    always_comb
    begin
        if (keep_count_reg == '0 || 32'(keep_count_reg) > MAX_KEEP)
        begin
            keep_eff = KW'(MAX_KEEP);
        end
        else
        begin
            keep_eff = KW'(keep_count_reg);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEEP; gi++)
        begin : g_range
            assign main_range[gi] = 32'(keep_eff) > gi;
        end
    endgenerate

    // Handshake decode
    assign in_acc     = sample_in.valid & sample_ready;
    assign drain_move = drain_active && !loaded_reg && main_valid[0];
    assign drain_done = drain_active && !loaded_reg && !main_valid[0];
    assign emit_shift = loaded_reg && sort_valid[0] && (!out_valid_reg || result_out.ready);

    generate
        if (MAX_KEEP > 1)
        begin : g_last_multi
            assign emit_last = !sort_valid[1];
        end
        else
        begin : g_last_single
            assign emit_last = 1'b1;
        end
    endgenerate

    // Advance the row state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_acc && sample_in.row_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // Decode state outputs
    always_comb
    begin
        case (state_reg)
            ST_COLLECT:
            begin
                sample_ready = 1'b1;
                drain_active = 1'b0;
            end
            ST_DRAIN:
            begin
                sample_ready = 1'b0;
                drain_active = 1'b1;
            end
            default:
            begin
                sample_ready = 1'b0;
                drain_active = 1'b0;
            end
        endcase
    end

    // Saturate the position; count elements and track overflow
    assign sample_position = counter_reg[POSITION_BITS] ? {POSITION_BITS{1'b1}}
                                                        : counter_reg[POSITION_BITS-1:0];

    always_comb
    begin
        counter_next  = counter_reg;
        overflow_next = overflow_reg;
        row_ovf_next  = row_ovf_reg;
        if (in_acc)
        begin
            if (sample_in.row_end)
            begin
                counter_next  = '0;
                overflow_next = 1'b0;
                row_ovf_next  = overflow_reg | counter_reg[POSITION_BITS];
            end
            else if (counter_reg[POSITION_BITS])
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                counter_next = counter_reg + 1'b1;
            end
        end
    end

    // Chain controls
    always_comb
    begin
        main_ctrl.cmp = want_largest_reg ? CMP_LARGEST : CMP_SMALLEST;
        if (in_acc)
        begin
            main_ctrl.op = OP_INSERT;
        end
        else if (drain_move)
        begin
            main_ctrl.op = OP_SHIFT;
        end
        else
        begin
            main_ctrl.op = OP_HOLD;
        end

        sort_ctrl.cmp = sorted_mode_reg ? CMP_APPEND : CMP_POSITION;
        if (drain_move)
        begin
            sort_ctrl.op = OP_INSERT;
        end
        else if (emit_shift)
        begin
            sort_ctrl.op = OP_SHIFT;
        end
        else
        begin
            sort_ctrl.op = OP_HOLD;
        end
    end

    // Mark the output chain loaded after drain; release on the last result
    always_comb
    begin
        loaded_next       = loaded_reg;
        out_long_src_next = out_long_src_reg;
        if (drain_done)
        begin
            loaded_next       = 1'b1;
            out_long_src_next = row_ovf_reg;
        end
        else if (emit_shift && emit_last)
        begin
            loaded_next = 1'b0;
        end
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_shift)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            counter_reg   <= '0;
            overflow_reg  <= 1'b0;
            row_ovf_reg   <= 1'b0;
            loaded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            overflow_reg  <= overflow_next;
            row_ovf_reg   <= row_ovf_next;
            loaded_reg    <= loaded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        out_long_src_reg <= out_long_src_next;
        if (emit_shift)
        begin
            out_value_reg    <= sort_head_value;
            out_position_reg <= sort_head_position;
            out_final_reg    <= emit_last;
            out_long_reg     <= out_long_src_reg;
        end
    end

    // Kept list, ranked by value
    tks_chain #(
        .MAX_KEEP      (MAX_KEEP),
        .VALUE_BITS    (VALUE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_main_chain (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (main_ctrl),
        .in_range      (main_range),
        .new_value     (sample_in.sample_value),
        .new_position  (sample_position),
        .taken         (main_taken),
        .valid_vec     (main_valid),
        .head_value    (main_head_value),
        .head_position (main_head_position)
    );

    // Output list, in emission order
    tks_chain #(
        .MAX_KEEP      (MAX_KEEP),
        .VALUE_BITS    (VALUE_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_sort_chain (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (sort_ctrl),
        .in_range      ({MAX_KEEP{1'b1}}),
        .new_value     (main_head_value),
        .new_position  (main_head_position),
        .taken         (sort_taken),
        .valid_vec     (sort_valid),
        .head_value    (sort_head_value),
        .head_position (sort_head_position)
    );

    // Drive channel ports
    assign sample_in.ready          = sample_ready;
    assign result_out.valid         = out_valid_reg;
    assign result_out.kept_value    = out_value_reg;
    assign result_out.kept_position = out_position_reg;
    assign result_out.final_result  = out_final_reg;
    assign result_out.row_too_long  = out_long_reg;

    // Checks
    `TKS_ASSERT_SAME(a_no_move_overlap, drain_move, !emit_shift,
        "drain and emit moved the output chain in the same cycle")
    `TKS_ASSERT_SAME(a_drain_fits, drain_move, sort_taken,
        "drained entry found no free output cell")
    `TKS_ASSERT_SAME(a_first_kept, in_acc && main_valid == '0, main_taken,
        "first element of a row was not kept")
    `TKS_ASSERT_SAME(a_main_prefix, 1'b1, ((main_valid >> 1) & ~main_valid) == '0,
        "kept list has a hole")
    `TKS_ASSERT_NEXT(a_loaded_nonempty, drain_done, loaded_reg && sort_valid[0],
        "row finished draining with no result to emit")

endmodule

// ===== src/tks_cell.sv =====
// ----------------------------------------------------------------------------
// Streaming top-k selector: list cell
// Holds one ranked entry; inserts a broadcast entry, takes its upper
// neighbor's entry when an earlier cell inserted, or takes its lower
// neighbor's entry when the list drains.
// ----------------------------------------------------------------------------
module tks_cell
    import tks_pkg::*;
#(
    parameter int VALUE_BITS    = DEF_VALUE_BITS,
    parameter int POSITION_BITS = DEF_POSITION_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cell_ctrl_t                      ctrl,
    input  logic                            in_range,
    input  logic signed [VALUE_BITS-1:0]    new_value,
    input  logic        [POSITION_BITS-1:0] new_position,
    input  logic                            hit_in,
    input  logic                            prev_valid,
    input  logic signed [VALUE_BITS-1:0]    prev_value,
    input  logic        [POSITION_BITS-1:0] prev_position,
    input  logic                            next_valid,
    input  logic signed [VALUE_BITS-1:0]    next_value,
    input  logic        [POSITION_BITS-1:0] next_position,
    output logic                            hit_out,
    output logic                            valid,
    output logic signed [VALUE_BITS-1:0]    value,
    output logic        [POSITION_BITS-1:0] position
);

    logic                            valid_reg;
    logic                            valid_next;
    logic signed [VALUE_BITS-1:0]    value_reg;
    logic signed [VALUE_BITS-1:0]    value_next;
    logic        [POSITION_BITS-1:0] position_reg;
    logic        [POSITION_BITS-1:0] position_next;
    logic                            valid_eff;
    logic                            beat;
    logic                            take;

    // Entries past the keep count read as empty
    assign valid_eff = valid_reg & in_range;

    // Rank the broadcast entry against the held one
    always_comb
    begin
        case (ctrl.cmp)
            CMP_LARGEST:
            begin
                beat = (new_value != value_reg) ? (new_value > value_reg)
                                                : (new_position < position_reg);
            end
            CMP_SMALLEST:
            begin
                beat = (new_value != value_reg) ? (new_value < value_reg)
                                                : (new_position < position_reg);
            end
            CMP_POSITION:
            begin
                beat = new_position < position_reg;
            end
            default:
            begin
                beat = 1'b0;
            end
        endcase
    end

    // Claim the slot if in range, no earlier cell did, and this one is beaten or free
    assign take    = !hit_in && in_range && (valid_eff ? beat : 1'b1);
    assign hit_out = hit_in | take;

    // Select the next entry
    always_comb
    begin
        valid_next    = valid_reg;
        value_next    = value_reg;
        position_next = position_reg;
        case (ctrl.op)
            OP_INSERT:
            begin
                if (take)
                begin
                    valid_next    = 1'b1;
                    value_next    = new_value;
                    position_next = new_position;
                end
                else if (hit_in)
                begin
                    valid_next    = prev_valid & in_range;
                    value_next    = prev_value;
                    position_next = prev_position;
                end
                else
                begin
                    valid_next = valid_eff;
                end
            end
            OP_SHIFT:
            begin
                valid_next    = next_valid;
                value_next    = next_value;
                position_next = next_position;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the entry payload
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        position_reg <= position_next;
    end

    assign valid    = valid_eff;
    assign value    = value_reg;
    assign position = position_reg;

endmodule

// ===== src/tks_chain.sv =====
// ----------------------------------------------------------------------------
// Streaming top-k selector: cell chain
// A ranked list of cells; the slot claim ripples from head to tail and
// entries move one cell per cycle on insert or drain.
// ----------------------------------------------------------------------------
module tks_chain
    import tks_pkg::*;
#(
    parameter int MAX_KEEP      = DEF_MAX_KEEP,
    parameter int VALUE_BITS    = DEF_VALUE_BITS,
    parameter int POSITION_BITS = DEF_POSITION_BITS
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cell_ctrl_t                      ctrl,
    input  logic        [MAX_KEEP-1:0]      in_range,
    input  logic signed [VALUE_BITS-1:0]    new_value,
    input  logic        [POSITION_BITS-1:0] new_position,
    output logic                            taken,
    output logic        [MAX_KEEP-1:0]      valid_vec,
    output logic signed [VALUE_BITS-1:0]    head_value,
    output logic        [POSITION_BITS-1:0] head_position
);

    logic                            hit     [MAX_KEEP];
    logic                            hit_out [MAX_KEEP];
    logic signed [VALUE_BITS-1:0]    value_arr    [MAX_KEEP];
    logic        [POSITION_BITS-1:0] position_arr [MAX_KEEP];

    genvar i;
    generate
        for (i = 0; i < MAX_KEEP; i++)
        begin : g_cell
            logic                            prev_valid;
            logic signed [VALUE_BITS-1:0]    prev_value;
            logic        [POSITION_BITS-1:0] prev_position;
            logic                            next_valid;
            logic signed [VALUE_BITS-1:0]    next_value;
            logic        [POSITION_BITS-1:0] next_position;

            // Upper neighbor feeds the insert shift
            if (i == 0)
            begin : g_head
                assign hit[i]        = 1'b0;
                assign prev_valid    = 1'b0;
                assign prev_value    = '0;
                assign prev_position = '0;
            end
            else
            begin : g_body
                assign hit[i]        = hit_out[i-1];
                assign prev_valid    = valid_vec[i-1];
                assign prev_value    = value_arr[i-1];
                assign prev_position = position_arr[i-1];
            end

            // Lower neighbor feeds the drain shift
            if (i == MAX_KEEP - 1)
            begin : g_tail
                assign next_valid    = 1'b0;
                assign next_value    = '0;
                assign next_position = '0;
            end
            else
            begin : g_inner
                assign next_valid    = valid_vec[i+1];
                assign next_value    = value_arr[i+1];
                assign next_position = position_arr[i+1];
            end

            tks_cell #(
                .VALUE_BITS    (VALUE_BITS),
                .POSITION_BITS (POSITION_BITS)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .ctrl          (ctrl),
                .in_range      (in_range[i]),
                .new_value     (new_value),
                .new_position  (new_position),
                .hit_in        (hit[i]),
                .prev_valid    (prev_valid),
                .prev_value    (prev_value),
                .prev_position (prev_position),
                .next_valid    (next_valid),
                .next_value    (next_value),
                .next_position (next_position),
                .hit_out       (hit_out[i]),
                .valid         (valid_vec[i]),
                .value         (value_arr[i]),
                .position      (position_arr[i])
            );
        end
    endgenerate

    assign taken         = hit_out[MAX_KEEP-1];
    assign head_value    = value_arr[0];
    assign head_position = position_arr[0];

endmodule
